@@ rtl/lrpf_pkg.sv @@
// Shared types and constants of the laser line row peak finder.
package lrpf_pkg;

  localparam int unsigned MaxColumns = 2048;
  localparam int unsigned MaxRows    = 1024;

  localparam int unsigned ColCntW  = 12;
  localparam int unsigned RowCntW  = 11;
  localparam int unsigned PixelW   = 8;
  localparam int unsigned BestColW = 11;
  localparam int unsigned RowOutW  = 10;
  localparam int unsigned FuncW    = 2;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 12;

  localparam logic [ColCntW-1:0] ColLimitMax  = ColCntW'(MaxColumns);
  localparam logic [RowCntW-1:0] RowLimitMax  = RowCntW'(MaxRows);
  localparam logic [ColCntW-1:0] ColCntSat    = {ColCntW{1'b1}};
  localparam logic [ColCntW-1:0] ColsUsedRst  = ColCntW'(640);
  localparam logic [RowCntW-1:0] RowsUsedRst  = RowCntW'(40);

  typedef enum logic [FuncW-1:0] {
    FUNC_PIXEL  = 2'd0,
    FUNC_EOL    = 2'd1,
    FUNC_SOF    = 2'd2,
    FUNC_UNUSED = 2'd3
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COLUMNS_USED = 1'b0,
    CFG_ROWS_USED    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [RowOutW-1:0]  row_index;
    logic [BestColW-1:0] peak_column;
    logic                last_row;
  } result_t;

endpackage

@@ rtl/lrpf_tracker.sv @@
// Line and frame tracking with the running peak search over the even columns of odd rows.
module lrpf_tracker import lrpf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic [FuncW-1:0]    func_i,
  input  logic [PixelW-1:0]   pixel_i,
  output logic                res_valid_o,
  output result_t             res_o
);

  logic [ColCntW-1:0]  cols_used_q, cols_used_d;
  logic [RowCntW-1:0]  rows_used_q, rows_used_d;
  logic [ColCntW-1:0]  col_cnt_q, col_cnt_d;
  logic [RowCntW-1:0]  row_cnt_q, row_cnt_d;
  logic [PixelW-1:0]   best_val_q, best_val_d;
  logic [BestColW-1:0] best_col_q, best_col_d;
  logic                active_q, active_d;

  logic [ColCntW-1:0]  col_limit;
  logic [RowCntW-1:0]  row_limit;
  logic [RowCntW:0]    row_next_wide;
  logic                last;
  logic                take;
  func_e               func;

  assign func = func_e'(func_i);

  always_comb begin
    col_limit = (cols_used_q > ColLimitMax) ? ColLimitMax : cols_used_q;
    if (rows_used_q > RowLimitMax) begin
      row_limit = RowLimitMax;
    end else if (rows_used_q == '0) begin
      row_limit = RowCntW'(1);
    end else begin
      row_limit = rows_used_q;
    end
    row_next_wide = {1'b0, row_cnt_q} + (RowCntW+1)'(1);
    last = row_next_wide >= {1'b0, row_limit};
    take = row_cnt_q[0] && !col_cnt_q[0] && (col_cnt_q < col_limit)
           && (pixel_i > best_val_q);
  end

  always_comb begin
    cols_used_d = cols_used_q;
    rows_used_d = rows_used_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_COLUMNS_USED: cols_used_d = cfg_data_i;
        CFG_ROWS_USED:    rows_used_d = cfg_data_i[RowCntW-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    col_cnt_d   = col_cnt_q;
    row_cnt_d   = row_cnt_q;
    best_val_d  = best_val_q;
    best_col_d  = best_col_q;
    active_d    = active_q;
    res_valid_o = 1'b0;
    res_o.row_index   = row_cnt_q[RowOutW-1:0];
    res_o.peak_column = row_cnt_q[0] ? best_col_q : '0;
    res_o.last_row    = last;
    if (in_valid_i) begin
      case (func)
        FUNC_SOF: begin
          active_d   = 1'b1;
          row_cnt_d  = '0;
          col_cnt_d  = '0;
          best_val_d = '0;
          best_col_d = '0;
        end
        FUNC_PIXEL: begin
          if (active_q) begin
            if (take) begin
              best_val_d = pixel_i;
              best_col_d = col_cnt_q[BestColW-1:0];
            end
            if (col_cnt_q != ColCntSat) begin
              col_cnt_d = col_cnt_q + ColCntW'(1);
            end
          end
        end
        FUNC_EOL: begin
          if (active_q) begin
            res_valid_o = 1'b1;
            row_cnt_d   = row_next_wide[RowCntW-1:0];
            if (last) begin
              active_d = 1'b0;
            end
            col_cnt_d  = '0;
            best_val_d = '0;
            best_col_d = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_used_q <= ColsUsedRst;
      rows_used_q <= RowsUsedRst;
      col_cnt_q   <= '0;
      row_cnt_q   <= '0;
      best_val_q  <= '0;
      best_col_q  <= '0;
      active_q    <= 1'b0;
    end else begin
      cols_used_q <= cols_used_d;
      rows_used_q <= rows_used_d;
      col_cnt_q   <= col_cnt_d;
      row_cnt_q   <= row_cnt_d;
      best_val_q  <= best_val_d;
      best_col_q  <= best_col_d;
      active_q    <= active_d;
    end
  end

endmodule

@@ rtl/lrpf_out_buf.sv @@
// Two-entry result buffer: output register plus skid register.
module lrpf_out_buf import lrpf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    space_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o,
  output logic    skid_valid_o
);

  logic    out_v_q, out_v_d;
  logic    skid_v_q, skid_v_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop = out_v_q && out_ready_i;

  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (pop) begin
      out_d    = skid_q;
      out_v_d  = skid_v_q;
      skid_v_d = 1'b0;
    end
    if (push_i) begin
      if (!out_v_d) begin
        out_d   = push_data_i;
        out_v_d = 1'b1;
      end else begin
        skid_d   = push_data_i;
        skid_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign space_o      = !skid_v_q;
  assign out_valid_o  = out_v_q;
  assign out_data_o   = out_q;
  assign skid_valid_o = skid_v_q;

endmodule

@@ rtl/laser_line_row_peak_finder.sv @@
// Laser line row peak finder: one item per clock cycle while s_axis_tready is
// high. Each accepted item updates the line and frame state in the same cycle;
// an end of line item places its result in the output register, or in the
// skid register if that one stays full. The result side holds two items (output
// register and skid register), so s_axis_tready drops only while both are full.
// Configuration writes take effect at the next clock edge.
module laser_line_row_peak_finder import lrpf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [7:0] pixel
  input  logic [FuncW-1:0]    s_axis_tuser,  // [1:0] func
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata,  // [9:0] row_index, [20:10] peak_column
  output logic                m_axis_tlast   // last_row
);

  logic    in_acc;
  logic    res_valid;
  result_t res;
  result_t out_res;
  logic    skid_valid;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  lrpf_tracker u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_acc),
    .func_i      (s_axis_tuser),
    .pixel_i     (s_axis_tdata[PixelW-1:0]),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  lrpf_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (res_valid),
    .push_data_i  (res),
    .space_o      (s_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (out_res),
    .skid_valid_o (skid_valid)
  );

  assign m_axis_tdata = {3'b000, out_res.peak_column, out_res.row_index};
  assign m_axis_tlast = out_res.last_row;

`ifndef NO_ASSERTIONS
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid |-> m_axis_tvalid)
    else $error("skid entry held with empty output register");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> s_axis_tready)
    else $error("result produced while buffer full");

  a_stall_keeps_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready && res_valid) |=> skid_valid)
    else $error("result lost during output stall");
`endif

endmodule
